// ----- src/fsl_pkg.sv -----
// Package for the force scheme layout block: command codes, register
// indexes, sequencer state type and the coordinate update helper.
// No dependencies.
package fsl_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = 6;
  localparam int CountW    = 7;

  typedef enum logic [1:0] {
    CMD_LOAD_DIST  = 2'd0,
    CMD_LOAD_POINT = 2'd1,
    CMD_LOAD_ORDER = 2'd2,
    CMD_RUN        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_ITER_COUNT  = 2'd1,
    REG_MIN_DIST    = 2'd2,
    REG_STEP_DIV    = 2'd3
  } reg_e;

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_ORDJ  = 18'b000000000000000010,
    S_ORDK  = 18'b000000000000000100,
    S_RDA   = 18'b000000000000001000,
    S_RDB   = 18'b000000000000010000,
    S_SUB   = 18'b000000000000100000,
    S_SQX   = 18'b000000000001000000,
    S_SQY   = 18'b000000000010000000,
    S_ROOT  = 18'b000000000100000000,
    S_CLAMP = 18'b000000001000000000,
    S_DIVS  = 18'b000000010000000000,
    S_MULX  = 18'b000000100000000000,
    S_DIVX  = 18'b000001000000000000,
    S_MULY  = 18'b000010000000000000,
    S_DIVY  = 18'b000100000000000000,
    S_WRITE = 18'b001000000000000000,
    S_NEXT  = 18'b010000000000000000,
    S_EMIT  = 18'b100000000000000000
  } state_e;

  // Clamp the move to 2^40, apply it with its sign and saturate to 32 bits.
  function automatic logic [31:0] move_coord(input logic [31:0] coord,
                                             input logic [63:0] q,
                                             input logic neg);
    logic [40:0] qc;
    logic signed [42:0] sum;
    qc = ((|q[63:41]) || (q[40] && (|q[39:0]))) ? {1'b1, 40'd0} : q[40:0];
    if (neg) begin
      sum = $signed({{11{coord[31]}}, coord}) - $signed({2'b00, qc});
    end else begin
      sum = $signed({{11{coord[31]}}, coord}) + $signed({2'b00, qc});
    end
    if (sum > 43'sh0007FFFFFFF) begin
      move_coord = 32'h7FFFFFFF;
    end else if (sum < -43'sh00080000000) begin
      move_coord = 32'h80000000;
    end else begin
      move_coord = sum[31:0];
    end
  endfunction

endpackage

// ----- src/force_scheme_layout.sv -----
// Force scheme layout: memories for targets, positions and order, plus a
// bit-serial multiply / divide / square-root datapath and its sequencer.
// Depends on fsl_pkg.

// Load commands (distance, point, order entry) return nothing. A run
// command keeps busy high for the whole run: every pair step goes through
// a one-bit-per-cycle datapath (two squares, a root, three divides and two
// multiplies), which is skipped when both order entries name the same
// point, and a run sweeps all n * n order pairs iteration_count times,
// followed by the n results. Results come one per cycle on result_valid_o
// in point order, starting the cycle after the emit phase begins; the
// receiver cannot stall them.
module force_scheme_layout import fsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [5:0]  first_index_i,
  input  logic [5:0]  second_index_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [5:0]  point_index_o,
  output logic [31:0] x_pos_o,
  output logic [31:0] y_pos_o,
  output logic        last_o
);

  logic [31:0] dist_mem  [MaxPoints*MaxPoints];
  logic [31:0] x_mem     [MaxPoints];
  logic [31:0] y_mem     [MaxPoints];
  logic [IdxW-1:0] ord_mem [MaxPoints];

  state_e state_q, state_d;

  logic [CountW-1:0] pcount_q;
  logic [9:0]  iter_q;
  logic [30:0] min_q;
  logic [30:0] sdiv_q;

  logic [CountW-1:0] n_q, n_d;
  logic [9:0]  it_q, it_d;
  logic [IdxW-1:0] j_q, j_d, k_q, k_d, e_q, e_d;
  logic [IdxW-1:0] a_q, a_d, b_q, b_d;
  logic [IdxW-1:0] nm1;

  logic [31:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d, tgt_q, tgt_d;
  logic [31:0] adx_q, adx_d, ady_q, ady_d, hy_q, hy_d;
  logic        dxneg_q, dxneg_d, dyneg_q, dyneg_d, sh_q, sh_d, eneg_q, eneg_d;
  logic [32:0] d_q, d_d;
  logic [31:0] nx_q, nx_d;
  logic [30:0] step_q, step_d;

  logic [63:0] acc_q, acc_d, mcand_q, mcand_d, quo_q, quo_d;
  logic [31:0] mplr_q, mplr_d, root_q, root_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] dvsr_q, dvsr_d;
  logic [5:0]  cnt_q, cnt_d;

  logic        rv_q, rv_d, last_q, last_d;
  logic [5:0]  pidx_q, pidx_d;

  logic [31:0] x_rd_q, y_rd_q, dist_rd_q;
  logic [IdxW-1:0] ord_rd_q;
  logic [IdxW-1:0] xy_raddr, ord_raddr;
  logic        xy_we;
  logic [IdxW-1:0] xy_waddr;
  logic [31:0] x_wdata, y_wdata;

  logic        accept;
  logic [63:0] acc_add;
  logic [35:0] sq_rem, sq_trial;
  logic [33:0] dv_rem;
  logic        dv_bit;
  logic [32:0] dx, dy;
  logic [31:0] adx_c, ady_c, hx_c;
  logic        sh_c;
  logic [32:0] d_raw, mn;
  logic [34:0] err;
  logic [33:0] aerr;
  logic [30:0] step_sat;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign nm1         = IdxW'(n_q - CountW'(1));

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= 7'd2;
      iter_q   <= 10'd50;
      min_q    <= 31'd66;
      sdiv_q   <= 31'd524288;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_POINT_COUNT: pcount_q <= cfg_data_i[6:0];
        REG_ITER_COUNT:  iter_q   <= cfg_data_i[9:0];
        REG_MIN_DIST:    min_q    <= cfg_data_i[30:0];
        REG_STEP_DIV:    sdiv_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (accept && command_i == CMD_LOAD_DIST) begin
      dist_mem[{first_index_i, second_index_i}] <= value_a_i;
    end
    if (accept && command_i == CMD_LOAD_ORDER) begin
      ord_mem[first_index_i] <= second_index_i;
    end
    if (xy_we) begin
      x_mem[xy_waddr] <= x_wdata;
      y_mem[xy_waddr] <= y_wdata;
    end
    x_rd_q    <= x_mem[xy_raddr];
    y_rd_q    <= y_mem[xy_raddr];
    ord_rd_q  <= ord_mem[ord_raddr];
    dist_rd_q <= dist_mem[{a_q, b_q}];
  end

  always_comb begin
    xy_we    = 1'b0;
    xy_waddr = b_q;
    x_wdata  = nx_q;
    y_wdata  = move_coord(yb_q, quo_q, eneg_q ^ dyneg_q);
    if (accept && command_i == CMD_LOAD_POINT) begin
      xy_we    = 1'b1;
      xy_waddr = first_index_i;
      x_wdata  = value_a_i;
      y_wdata  = value_b_i;
    end else if (state_q == S_WRITE) begin
      xy_we = 1'b1;
    end
  end

  always_comb begin
    ord_raddr = (state_q == S_ORDK) ? k_q : j_q;
    case (state_q)
      S_RDA:   xy_raddr = a_q;
      S_EMIT:  xy_raddr = e_q;
      default: xy_raddr = b_q;
    endcase
  end

  // Datapath helpers
  assign acc_add  = acc_q + (mplr_q[0] ? mcand_q : 64'd0);
  assign sq_rem   = {rem_q, quo_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign dv_rem   = {rem_q[32:0], quo_q[63]};
  assign dv_bit   = (dv_rem >= {1'b0, dvsr_q});

  assign dx    = {x_rd_q[31], x_rd_q} - {xa_q[31], xa_q};
  assign dy    = {y_rd_q[31], y_rd_q} - {ya_q[31], ya_q};
  assign adx_c = dx[32] ? 32'(-dx) : dx[31:0];
  assign ady_c = dy[32] ? 32'(-dy) : dy[31:0];
  assign sh_c  = adx_c[31] | ady_c[31];
  assign hx_c  = sh_c ? (adx_c >> 1) : adx_c;

  assign d_raw = sh_q ? {root_q, 1'b0} : {1'b0, root_q};
  assign mn    = (min_q == 31'd0) ? 33'd1 : {2'b00, min_q};
  assign err   = {{3{tgt_q[31]}}, tgt_q} - {2'b00, ((d_raw < mn) ? mn : d_raw)};
  assign aerr  = err[34] ? 34'(-err) : err[33:0];
  // quotient after the final divide cycle is {quo_q[62:0], dv_bit}
  assign step_sat = (|quo_q[62:30]) ? 31'h7FFFFFFF : {quo_q[29:0], dv_bit};

  always_comb begin
    state_d = state_q;
    n_d = n_q; it_d = it_q; j_d = j_q; k_d = k_q; e_d = e_q;
    a_d = a_q; b_d = b_q;
    xa_d = xa_q; ya_d = ya_q; xb_d = xb_q; yb_d = yb_q; tgt_d = tgt_q;
    adx_d = adx_q; ady_d = ady_q; hy_d = hy_q;
    dxneg_d = dxneg_q; dyneg_d = dyneg_q; sh_d = sh_q; eneg_d = eneg_q;
    d_d = d_q; nx_d = nx_q; step_d = step_q;
    acc_d = acc_q; mcand_d = mcand_q; quo_d = quo_q; mplr_d = mplr_q;
    root_d = root_q; rem_d = rem_q; dvsr_d = dvsr_q; cnt_d = cnt_q;
    rv_d = 1'b0; last_d = 1'b0; pidx_d = pidx_q;

    case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_RUN) begin
          n_d  = (pcount_q > CountW'(MaxPoints)) ? CountW'(MaxPoints) : pcount_q;
          it_d = '0; j_d = '0; k_d = '0; e_d = '0;
          if (n_d == '0) begin
            state_d = S_IDLE;
          end else if (iter_q == 10'd0 || n_d < CountW'(2)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_ORDJ;
          end
        end
      end
      S_ORDJ: state_d = S_ORDK;
      S_ORDK: begin
        a_d = ord_rd_q;
        state_d = S_RDA;
      end
      S_RDA: begin
        b_d = ord_rd_q;
        state_d = (ord_rd_q == a_q) ? S_NEXT : S_RDB;
      end
      S_RDB: begin
        xa_d = x_rd_q;
        ya_d = y_rd_q;
        state_d = S_SUB;
      end
      S_SUB: begin
        xb_d = x_rd_q; yb_d = y_rd_q; tgt_d = dist_rd_q;
        adx_d = adx_c; ady_d = ady_c; dxneg_d = dx[32]; dyneg_d = dy[32];
        sh_d = sh_c;
        hy_d = sh_c ? (ady_c >> 1) : ady_c;
        acc_d = '0; mcand_d = {32'd0, hx_c}; mplr_d = hx_c; cnt_d = '0;
        state_d = S_SQX;
      end
      S_SQX, S_SQY, S_MULX, S_MULY: begin
        acc_d = acc_add; mcand_d = mcand_q << 1; mplr_d = mplr_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (state_q == S_MULY && cnt_q == 6'd0) begin
          nx_d = move_coord(xb_q, quo_q, eneg_q ^ dxneg_q);
        end
        if (cnt_q == 6'd31) begin
          cnt_d = '0;
          case (state_q)
            S_SQX: begin
              mcand_d = {32'd0, hy_q}; mplr_d = hy_q;
              state_d = S_SQY;
            end
            S_SQY: begin
              quo_d = acc_add; rem_d = '0; root_d = '0;
              state_d = S_ROOT;
            end
            S_MULX: begin
              quo_d = acc_add; rem_d = '0; dvsr_d = d_q;
              state_d = S_DIVX;
            end
            default: begin
              quo_d = acc_add; rem_d = '0; dvsr_d = d_q;
              state_d = S_DIVY;
            end
          endcase
        end
      end
      S_ROOT: begin
        // two radicand bits per cycle, one root bit
        quo_d = quo_q << 2;
        if (sq_rem >= sq_trial) begin
          rem_d  = 34'(sq_rem - sq_trial);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = sq_rem[33:0];
          root_d = {root_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          cnt_d = '0;
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        d_d    = (d_raw < mn) ? mn : d_raw;
        eneg_d = err[34];
        quo_d  = {14'd0, aerr, 16'd0};
        rem_d  = '0;
        dvsr_d = (sdiv_q == 31'd0) ? 33'd1 : {2'b00, sdiv_q};
        cnt_d  = '0;
        state_d = S_DIVS;
      end
      S_DIVS, S_DIVX, S_DIVY: begin
        rem_d = dv_bit ? 34'(dv_rem - {1'b0, dvsr_q}) : dv_rem;
        quo_d = {quo_q[62:0], dv_bit};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          cnt_d = '0;
          case (state_q)
            S_DIVS: begin
              step_d = step_sat;
              acc_d = '0; mcand_d = {32'd0, adx_q}; mplr_d = {1'b0, step_sat};
              state_d = S_MULX;
            end
            S_DIVX: begin
              acc_d = '0; mcand_d = {32'd0, ady_q}; mplr_d = {1'b0, step_q};
              state_d = S_MULY;
            end
            default: state_d = S_WRITE;
          endcase
        end
      end
      S_WRITE: state_d = S_NEXT;
      S_NEXT: begin
        state_d = S_ORDJ;
        k_d = k_q + IdxW'(1);
        if (k_q == nm1) begin
          k_d = '0;
          j_d = j_q + IdxW'(1);
          if (j_q == nm1) begin
            j_d  = '0;
            it_d = it_q + 10'd1;
            if (it_q == iter_q - 10'd1) begin
              e_d = '0;
              state_d = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        rv_d   = 1'b1;
        pidx_d = e_q;
        last_d = (e_q == nm1);
        e_d    = e_q + IdxW'(1);
        if (e_q == nm1) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q  <= '0;
      it_q <= '0;
      j_q  <= '0;
      k_q  <= '0;
      e_q  <= '0;
      cnt_q <= '0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q  <= n_d;
      it_q <= it_d;
      j_q  <= j_d;
      k_q  <= k_d;
      e_q  <= e_d;
      cnt_q <= cnt_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d;
    xa_q <= xa_d; ya_q <= ya_d; xb_q <= xb_d; yb_q <= yb_d; tgt_q <= tgt_d;
    adx_q <= adx_d; ady_q <= ady_d; hy_q <= hy_d;
    dxneg_q <= dxneg_d; dyneg_q <= dyneg_d; sh_q <= sh_d; eneg_q <= eneg_d;
    d_q <= d_d; nx_q <= nx_d; step_q <= step_d;
    acc_q <= acc_d; mcand_q <= mcand_d; quo_q <= quo_d; mplr_q <= mplr_d;
    root_q <= root_d; rem_q <= rem_d; dvsr_q <= dvsr_d;
    last_q <= last_d; pidx_q <= pidx_d;
  end

  assign result_valid_o = rv_q;
  assign point_index_o  = pidx_q;
  assign x_pos_o        = x_rd_q;
  assign y_pos_o        = y_rd_q;
  assign last_o         = last_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for force_scheme_layout: loads targets, points and
// visiting orders, runs short layouts and checks every emitted position.
// Depends on fsl_pkg and force_scheme_layout.
module testbench;
  import fsl_pkg::*;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } pos_t;

  typedef struct {
    bit          is_cfg;
    reg_e        rg;
    cmd_e        cmd;
    logic [5:0]  i1;
    logic [5:0]  i2;
    logic [31:0] va;
    logic [31:0] vb;
    bit          known;
    logic [31:0] x0, y0, x1, y1;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = CMD_LOAD_DIST;
  logic [5:0]  first_index_i = '0;
  logic [5:0]  second_index_i = '0;
  logic [31:0] value_a_i = '0;
  logic [31:0] value_b_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_POINT_COUNT;
  logic [31:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [5:0]  point_index_o;
  logic [31:0] x_pos_o, y_pos_o;
  logic        last_o;

  force_scheme_layout u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // layout state mirror
  logic signed [31:0] target_mem [4096];
  logic signed [31:0] xs [64];
  logic signed [31:0] ys [64];
  logic [5:0]         visit [64];
  bit                 target_set [4096];
  bit                 point_set [64];
  bit                 visit_set [64];
  logic [6:0]         n_points = 7'd2;
  logic [9:0]         n_sweeps = 10'd50;
  logic [30:0]        dmin = 31'd66;
  logic [30:0]        ddiv = 31'd524288;

  pos_t positions_due [$];
  bit   typed_exp = 1'b0;
  int   errors = 0;
  int   sent = 0;
  int   burst = 0;

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] nudge(logic [31:0] c, longint comp, logic [63:0] step,
                                        bit sneg, logic [63:0] d);
    logic [63:0] m, q;
    bit neg;
    m = comp < 0 ? -comp : comp;
    q = step * m / d;
    neg = sneg != (comp < 0);
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return clip32(neg ? longint'($signed(c)) - longint'(q) : longint'($signed(c)) + longint'(q));
  endfunction

  task automatic pull_pair(int a, int b);
    longint dx, dy, err;
    logic [63:0] ax, ay, d, mn, dv, ae, step;
    int sh;
    dx = longint'(xs[b]) - longint'(xs[a]);
    dy = longint'(ys[b]) - longint'(ys[a]);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sh = 0;
    if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
      ax >>= 1;
      ay >>= 1;
      sh = 1;
    end
    d = root64(ax * ax + ay * ay) << sh;
    mn = (dmin == 0) ? 64'd1 : 64'(dmin);
    if (d < mn) d = mn;
    err = longint'(target_mem[a * 64 + b]) - longint'(d);
    dv = (ddiv == 0) ? 64'd1 : 64'(ddiv);
    ae = err < 0 ? -err : err;
    step = (ae << 16) / dv;
    if (step > 64'h7FFF_FFFF) step = 64'h7FFF_FFFF;
    xs[b] = nudge(xs[b], dx, step, err < 0, d);
    ys[b] = nudge(ys[b], dy, step, err < 0, d);
  endtask

  task automatic layout_apply(cmd_e c, logic [5:0] i1, logic [5:0] i2,
                              logic [31:0] va, logic [31:0] vb);
    int n;
    pos_t p;
    case (c)
      CMD_LOAD_DIST: begin
        target_mem[i1 * 64 + i2] = va;
        target_set[i1 * 64 + i2] = 1'b1;
      end
      CMD_LOAD_POINT: begin
        xs[i1] = va;
        ys[i1] = vb;
        point_set[i1] = 1'b1;
      end
      CMD_LOAD_ORDER: begin
        visit[i1] = i2;
        visit_set[i1] = 1'b1;
      end
      default: begin
        n = (n_points > 64) ? 64 : int'(n_points);
        for (int it = 0; it < n_sweeps; it++)
          for (int j = 0; j < n; j++)
            for (int k = 0; k < n; k++)
              if (visit[j] != visit[k]) pull_pair(visit[j], visit[k]);
        if (!typed_exp) begin
          for (int j = 0; j < n; j++) begin
            p.idx = 6'(j);
            p.x = xs[j];
            p.y = ys[j];
            p.last = (j + 1 == n);
            positions_due.push_back(p);
          end
        end
      end
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    pos_t e;
    if (rst_ni && result_valid_o) begin
      if (positions_due.size() == 0) begin
        $display("%0t unexpected result: idx %0d x %h y %h last %b", $time,
                 point_index_o, x_pos_o, y_pos_o, last_o);
        errors++;
      end else begin
        e = positions_due.pop_front();
        if (point_index_o !== e.idx || x_pos_o !== e.x || y_pos_o !== e.y ||
            last_o !== e.last) begin
          $display("%0t mismatch: expected idx %0d x %h y %h last %b, got idx %0d x %h y %h last %b",
                   $time, e.idx, e.x, e.y, e.last, point_index_o, x_pos_o, y_pos_o, last_o);
          errors++;
        end
      end
    end
  end

  task automatic send(cmd_e c, logic [5:0] i1, logic [5:0] i2,
                      logic [31:0] va, logic [31:0] vb);
    if (burst == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst--;
    start <= 1'b1;
    command_i <= c;
    first_index_i <= i1;
    second_index_i <= i2;
    value_a_i <= va;
    value_b_i <= vb;
    do @(posedge clk_i); while (busy);
    layout_apply(c, i1, i2, va, vb);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    burst = 0;
    @(posedge clk_i);
    while (positions_due.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_e r, logic [31:0] v);
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_POINT_COUNT: n_points = v[6:0];
      REG_ITER_COUNT:  n_sweeps = v[9:0];
      REG_MIN_DIST:    dmin = v[30:0];
      default:         ddiv = v[30:0];
    endcase
  endtask

  function automatic logic [31:0] pick_coord();
    int s;
    s = $urandom_range(0, 19);
    if (s < 12) return $urandom_range(0, 20 << 16) - (10 << 16);
    if (s < 17) return $urandom;
    case ($urandom_range(0, 2))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    if ($urandom_range(0, 5) != 0) return $urandom_range(0, 16 << 16);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_scale(bit is_div);
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      4: return $urandom_range(1, 1 << 12);
      default: return is_div ? $urandom_range(1 << 16, 1 << 20) : $urandom_range(1, 1 << 16);
    endcase
  endfunction

  function automatic row_t op(cmd_e c, logic [5:0] i1, logic [5:0] i2,
                              logic [31:0] va, logic [31:0] vb);
    row_t r;
    r = '{rg: REG_POINT_COUNT, cmd: CMD_LOAD_DIST, default: '0};
    r.cmd = c;
    r.i1 = i1;
    r.i2 = i2;
    r.va = va;
    r.vb = vb;
    return r;
  endfunction

  function automatic row_t reg_op(reg_e g, logic [31:0] v);
    row_t r;
    r = '{rg: REG_POINT_COUNT, cmd: CMD_LOAD_DIST, default: '0};
    r.is_cfg = 1'b1;
    r.rg = g;
    r.va = v;
    return r;
  endfunction

  initial begin
    row_t tab [$];
    row_t r;
    int n, lim, nl;
    int a, b;
    cmd_e c;

    // directed: saturated corners, zero registers, repeated order, tiny counts
    tab.push_back(reg_op(REG_ITER_COUNT, 0));
    tab.push_back(op(CMD_LOAD_POINT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    tab.push_back(op(CMD_LOAD_POINT, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    r = op(CMD_RUN, 0, 0, 0, 0);
    r.known = 1'b1;
    r.x0 = 32'h7FFF_FFFF; r.y0 = 32'h8000_0000;
    r.x1 = 32'h8000_0000; r.y1 = 32'h7FFF_FFFF;
    tab.push_back(r);
    tab.push_back(op(CMD_LOAD_DIST, 0, 1, 32'h0001_0000, 0));
    tab.push_back(op(CMD_LOAD_DIST, 1, 0, 32'h7FFF_FFFF, 0));
    tab.push_back(op(CMD_LOAD_ORDER, 0, 0, 0, 0));
    tab.push_back(op(CMD_LOAD_ORDER, 1, 1, 0, 0));
    tab.push_back(reg_op(REG_ITER_COUNT, 1));
    tab.push_back(reg_op(REG_MIN_DIST, 0));
    tab.push_back(reg_op(REG_STEP_DIV, 0));
    tab.push_back(op(CMD_RUN, 0, 0, 0, 0));
    tab.push_back(reg_op(REG_MIN_DIST, 32'h7FFF_FFFF));
    tab.push_back(reg_op(REG_STEP_DIV, 32'h7FFF_FFFF));
    tab.push_back(op(CMD_LOAD_POINT, 1, 0, 32'h0003_0000, 32'hFFFC_0000));
    tab.push_back(op(CMD_RUN, 0, 0, 0, 0));
    tab.push_back(op(CMD_LOAD_ORDER, 0, 1, 0, 0));
    tab.push_back(op(CMD_RUN, 0, 0, 0, 0));
    tab.push_back(reg_op(REG_POINT_COUNT, 1));
    tab.push_back(op(CMD_RUN, 0, 0, 0, 0));
    tab.push_back(reg_op(REG_POINT_COUNT, 0));
    tab.push_back(op(CMD_RUN, 0, 0, 0, 0));
    tab.push_back(reg_op(REG_POINT_COUNT, 2));
    tab.push_back(reg_op(REG_ITER_COUNT, 1023));
    tab.push_back(reg_op(REG_ITER_COUNT, 2));
    tab.push_back(reg_op(REG_MIN_DIST, 66));
    tab.push_back(reg_op(REG_STEP_DIV, 1 << 17));
    tab.push_back(op(CMD_LOAD_ORDER, 0, 0, 0, 0));
    tab.push_back(op(CMD_LOAD_DIST, 0, 1, 32'h8000_0000, 0));
    tab.push_back(op(CMD_LOAD_POINT, 0, 0, 32'h0000_0000, 32'h0000_0000));
    tab.push_back(op(CMD_LOAD_POINT, 63, 63, 32'hFFFF_FFFF, 32'h5555_AAAA));
    tab.push_back(op(CMD_LOAD_DIST, 63, 63, 32'hAAAA_5555, 0));
    tab.push_back(op(CMD_LOAD_ORDER, 63, 63, 0, 0));
    tab.push_back(op(CMD_RUN, 0, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tab[i]) begin
      r = tab[i];
      if (r.is_cfg) begin
        settle();
        cfg_write(r.rg, r.va);
      end else begin
        if (r.known) begin
          typed_exp = 1'b1;
          positions_due.push_back('{6'd0, r.x0, r.y0, 1'b0});
          positions_due.push_back('{6'd1, r.x1, r.y1, 1'b1});
        end
        send(r.cmd, r.i1, r.i2, r.va, r.vb);
        typed_exp = 1'b0;
      end
    end

    // random layouts: mostly well-formed load sets followed by a run
    for (int ph = 0; sent < 260; ph++) begin
      settle();
      if (ph == 2) begin
        n = 64;
        cfg_write(REG_POINT_COUNT, 64);
        cfg_write(REG_ITER_COUNT, 0);
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6) : $urandom_range(2, 4);
        cfg_write(REG_POINT_COUNT, n);
        cfg_write(REG_ITER_COUNT, n > 4 ? 1 : $urandom_range(1, 3));
        cfg_write(REG_MIN_DIST, pick_scale(1'b0));
        cfg_write(REG_STEP_DIV, pick_scale(1'b1));
      end
      nl = $urandom_range(6, 20);
      for (int q = 0; q < nl; q++) begin
        lim = ($urandom_range(0, 4) == 0) ? 63 : n - 1;
        c = cmd_e'($urandom_range(0, 2));
        send(c, 6'($urandom_range(0, lim)), 6'($urandom_range(0, lim)),
             (c == CMD_LOAD_DIST) ? pick_target() : pick_coord(), $urandom);
      end
      // fill whatever the run would read but was never loaded
      if (n_sweeps != 0)
        for (int j = 0; j < n; j++)
          if (!visit_set[j])
            send(CMD_LOAD_ORDER, 6'(j), ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                            : 6'($urandom_range(0, n - 1)), 0, 0);
      for (int j = 0; j < n; j++) begin
        if (!point_set[j]) send(CMD_LOAD_POINT, 6'(j), 0, pick_coord(), pick_coord());
        if (n_sweeps != 0 && !point_set[visit[j]])
          send(CMD_LOAD_POINT, visit[j], 0, pick_coord(), pick_coord());
      end
      if (n_sweeps != 0)
        for (int j = 0; j < n; j++)
          for (int k = 0; k < n; k++) begin
            a = visit[j];
            b = visit[k];
            if (a != b && !target_set[a * 64 + b])
              send(CMD_LOAD_DIST, 6'(a), 6'(b), pick_target(), 0);
          end
      send(CMD_RUN, 6'($urandom), 6'($urandom), $urandom, $urandom);
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && positions_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
